// File: src/mbrf_pkg.sv
// ----------------------------------------------------------------------------
// mbrf_pkg
// Shared types and constants of the multichannel burst ring FIFO.
// ----------------------------------------------------------------------------
package mbrf_pkg;

   localparam int DEPTH_DEFAULT    = 64;
   localparam int CHANNELS_DEFAULT = 4;
   localparam int DEPTH_MAX        = 4096;

   localparam int SAMPLE_W = 16;
   localparam int CHAN_W   = 2;
   localparam int LEN_W    = 7;

   localparam int PTR_MAX_W  = $clog2(DEPTH_MAX);
   localparam int FILL_MAX_W = $clog2(DEPTH_MAX + 1);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_PULL = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_EMPTY  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CMD_STATUS = 2'd0,
      CMD_EMPTY  = 2'd1,
      CMD_DRAIN  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      op_type                     opcode;
      logic [CHAN_W-1:0]          channel;
      logic signed [SAMPLE_W-1:0] sample;
      logic [LEN_W-1:0]           burst_len;
      logic                       first_of_burst;
   } req_type;

   typedef struct packed {
      kind_type                   kind;
      logic [CHAN_W-1:0]          out_channel;
      logic signed [SAMPLE_W-1:0] out_sample;
      logic [LEN_W-1:0]           accepted_count;
      logic                       last;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [CHAN_W-1:0]     channel;
      logic [LEN_W-1:0]      count;
      logic [PTR_MAX_W-1:0]  start;
      logic [FILL_MAX_W-1:0] length;
   } cmd_type;

endpackage

// File: src/mbrf_ram.sv
// ----------------------------------------------------------------------------
// mbrf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbrf_ram #(
   parameter int DATA_W = 16,
   parameter int WORDS  = 256,
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/mbrf_queue.sv
// ----------------------------------------------------------------------------
// mbrf_queue
// Short command FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module mbrf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  mbrf_pkg::cmd_type in_data,
   output logic              out_valid,
   input  logic              out_pop,
   output mbrf_pkg::cmd_type out_data
);

   localparam int QD  = mbrf_pkg::QUEUE_DEPTH;
   localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
   localparam int QCW = $clog2(QD + 1);

   mbrf_pkg::cmd_type entry_ff [QD];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign in_ready  = (cnt_ff != QCW'(QD));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QD - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QD - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + QCW'(do_push) - QCW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: src/mbrf_front.sv
// ----------------------------------------------------------------------------
// mbrf_front
// Accepts words, tracks the open burst, writes admitted samples, keeps the
// per-channel pointers and fill counts, and queues result commands.
// ----------------------------------------------------------------------------
module mbrf_front #(
   parameter int DEPTH    = mbrf_pkg::DEPTH_DEFAULT,
   parameter int CHANNELS = mbrf_pkg::CHANNELS_DEFAULT,
   localparam int AW      = $clog2(CHANNELS * DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mbrf_pkg::req_type             req_data,
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output logic [mbrf_pkg::SAMPLE_W-1:0] wr_data,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output mbrf_pkg::cmd_type             cmd_data,
   input  logic                          drain_done
);

   localparam int PW  = $clog2(DEPTH);
   localparam int FW  = $clog2(DEPTH + 1);
   localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int LW  = mbrf_pkg::LEN_W;
   localparam int SW  = ((PW > LW) ? PW : LW) + 1;
   localparam int CW  = ((FW > LW) ? FW : LW) + 1;
   localparam int RW  = ((PW > FW) ? PW : FW) + 1;
   localparam int DCW = $clog2(mbrf_pkg::QUEUE_DEPTH + 2);

   logic [PW-1:0]  wp_ff [CHANNELS];
   logic [PW-1:0]  wp_in [CHANNELS];
   logic [PW-1:0]  rp_ff [CHANNELS];
   logic [PW-1:0]  rp_in [CHANNELS];
   logic [FW-1:0]  fill_ff [CHANNELS];
   logic [FW-1:0]  fill_in [CHANNELS];
   logic           burst_acc_ff, burst_acc_in;
   logic [LW-1:0]  burst_rem_ff, burst_rem_in;
   logic [LW-1:0]  burst_off_ff, burst_off_in;
   logic [LW-1:0]  burst_len_ff, burst_len_in;
   logic [mbrf_pkg::CHAN_W-1:0] burst_ch_ff, burst_ch_in;
   logic [DCW-1:0] drain_cnt_ff, drain_cnt_in;

   logic                        is_push, first, ch_ok, fire, blocked;
   logic [mbrf_pkg::CHAN_W-1:0] sel_ch;
   logic [CIW-1:0]              sel_idx;
   logic [PW-1:0]               wp_sel, rp_sel, pos, wp_next, rp_next;
   logic [FW-1:0]               fill_sel;
   logic [CW-1:0]               space;
   logic                        admit, start_burst, zero_burst, cont, do_pull, step;
   logic                        acc_cur, commit_end;
   logic [LW-1:0]               off_cur, len_cur, rem_cur, rem_next;
   logic [SW-1:0]               psum, wsum;
   logic [RW-1:0]               rsum;
   logic [AW:0]                 addr_full;

   always_comb begin
      is_push  = (req_data.opcode == mbrf_pkg::OP_PUSH);
      first    = req_data.first_of_burst;
      ch_ok    = (int'(req_data.channel) < CHANNELS);
      // continuation samples follow the channel latched on the first sample
      sel_ch   = (is_push && !first) ? burst_ch_ff : req_data.channel;
      sel_idx  = CIW'(sel_ch);
      wp_sel   = wp_ff[sel_idx];
      rp_sel   = rp_ff[sel_idx];
      fill_sel = fill_ff[sel_idx];

      space = CW'(DEPTH) - CW'(fill_sel);
      admit = (space > CW'(req_data.burst_len));

      start_burst = is_push && first && ch_ok && (req_data.burst_len != '0);
      zero_burst  = is_push && first && ch_ok && (req_data.burst_len == '0);
      cont        = is_push && !first && (burst_rem_ff != '0);
      do_pull     = !is_push && ch_ok;
      step        = start_burst || cont;

      acc_cur  = first ? admit : burst_acc_ff;
      off_cur  = first ? '0 : burst_off_ff;
      len_cur  = first ? req_data.burst_len : burst_len_ff;
      rem_cur  = first ? req_data.burst_len : burst_rem_ff;
      rem_next = rem_cur - 1'b1;
      commit_end = step && (rem_next == '0);

      psum    = SW'(wp_sel) + SW'(off_cur);
      pos     = (psum >= SW'(DEPTH)) ? PW'(psum - SW'(DEPTH)) : PW'(psum);
      wsum    = SW'(wp_sel) + SW'(len_cur);
      wp_next = (wsum >= SW'(DEPTH)) ? PW'(wsum - SW'(DEPTH)) : PW'(wsum);
      rsum    = RW'(rp_sel) + RW'(fill_sel);
      rp_next = (rsum >= RW'(DEPTH)) ? PW'(rsum - RW'(DEPTH)) : PW'(rsum);

      // no sample write while a drain still has reads outstanding
      blocked   = is_push && (drain_cnt_ff != '0);
      req_ready = cmd_ready && !blocked;
      fire      = req_valid && req_ready;

      addr_full = (AW + 1)'(sel_idx) * (AW + 1)'(DEPTH) + (AW + 1)'(pos);
      wr_en     = fire && step && acc_cur;
      wr_addr   = addr_full[AW-1:0];
      wr_data   = req_data.sample;

      cmd_valid        = fire && (zero_burst || commit_end || do_pull);
      cmd_data.channel = sel_ch;
      cmd_data.start   = mbrf_pkg::PTR_MAX_W'(rp_sel);
      cmd_data.length  = mbrf_pkg::FILL_MAX_W'(fill_sel);
      cmd_data.count   = (step && acc_cur) ? len_cur : '0;
      if (do_pull) begin
         cmd_data.kind = (fill_sel == '0) ? mbrf_pkg::CMD_EMPTY : mbrf_pkg::CMD_DRAIN;
      end else begin
         cmd_data.kind = mbrf_pkg::CMD_STATUS;
      end

      wp_in        = wp_ff;
      rp_in        = rp_ff;
      fill_in      = fill_ff;
      burst_acc_in = burst_acc_ff;
      burst_rem_in = burst_rem_ff;
      burst_off_in = burst_off_ff;
      burst_len_in = burst_len_ff;
      burst_ch_in  = burst_ch_ff;

      if (fire) begin
         if (zero_burst) begin
            burst_acc_in = 1'b0;
            burst_rem_in = '0;
            burst_off_in = '0;
         end
         if (step) begin
            burst_rem_in = rem_next;
            burst_off_in = off_cur + 1'b1;
            if (start_burst) begin
               burst_acc_in = admit;
               burst_len_in = req_data.burst_len;
               burst_ch_in  = req_data.channel;
            end
         end
         if (commit_end) begin
            burst_acc_in = 1'b0;
            burst_off_in = '0;
            if (acc_cur) begin
               wp_in[sel_idx]   = wp_next;
               fill_in[sel_idx] = fill_sel + FW'(len_cur);
            end
         end
         if (do_pull && (fill_sel != '0)) begin
            rp_in[sel_idx]   = rp_next;
            fill_in[sel_idx] = '0;
         end
      end

      drain_cnt_in = drain_cnt_ff
                   + DCW'(cmd_valid && (cmd_data.kind == mbrf_pkg::CMD_DRAIN))
                   - DCW'(drain_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            wp_ff[i]   <= '0;
            rp_ff[i]   <= '0;
            fill_ff[i] <= '0;
         end
         burst_acc_ff <= 1'b0;
         burst_rem_ff <= '0;
         burst_off_ff <= '0;
         burst_len_ff <= '0;
         burst_ch_ff  <= '0;
         drain_cnt_ff <= '0;
      end else begin
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         fill_ff      <= fill_in;
         burst_acc_ff <= burst_acc_in;
         burst_rem_ff <= burst_rem_in;
         burst_off_ff <= burst_off_in;
         burst_len_ff <= burst_len_in;
         burst_ch_ff  <= burst_ch_in;
         drain_cnt_ff <= drain_cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_write_during_drain: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (drain_cnt_ff == '0))
      else $error("sample write while a drain is outstanding");

   a_commit_fits: assert property (@(posedge clock) disable iff (reset)
      (fire && commit_end && acc_cur) |-> ((CW'(fill_sel) + CW'(len_cur)) < CW'(DEPTH)))
      else $error("committed burst overfills the ring");

   a_drain_cnt_no_underflow: assert property (@(posedge clock) disable iff (reset)
      drain_done |-> (drain_cnt_ff != '0))
      else $error("drain completion with no drain outstanding");
`endif

endmodule

// File: src/mbrf_back.sv
// ----------------------------------------------------------------------------
// mbrf_back
// Pops result commands, streams drained samples from the RAM one per cycle
// while the two-word output buffer that holds results has room.
// ----------------------------------------------------------------------------
module mbrf_back #(
   parameter int DEPTH    = mbrf_pkg::DEPTH_DEFAULT,
   parameter int CHANNELS = mbrf_pkg::CHANNELS_DEFAULT,
   localparam int AW      = $clog2(CHANNELS * DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_pop,
   input  mbrf_pkg::cmd_type             cmd_data,
   output logic                          rd_en,
   output logic [AW-1:0]                 rd_addr,
   input  logic [mbrf_pkg::SAMPLE_W-1:0] rd_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mbrf_pkg::rsp_type             rsp_data,
   output logic                          drain_done
);

   localparam int PW  = $clog2(DEPTH);
   localparam int FW  = $clog2(DEPTH + 1);
   localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic                        act_ff, act_in;
   logic [mbrf_pkg::CHAN_W-1:0] act_ch_ff, act_ch_in;
   logic [PW-1:0]               act_ptr_ff, act_ptr_in;
   logic [FW-1:0]               act_rem_ff, act_rem_in;
   logic                        s1_vld_ff, s1_vld_in;
   logic                        s1_ram_ff, s1_ram_in;
   mbrf_pkg::rsp_type           s1_meta_ff, s1_meta_in;
   mbrf_pkg::rsp_type           ob_ff [2];
   logic                        ob_wr_ff, ob_wr_in;
   logic                        ob_rd_ff, ob_rd_in;
   logic [1:0]                  ob_cnt_ff, ob_cnt_in;

   logic                        pop_out, room, act_last;
   logic [AW:0]                 addr_full;
   mbrf_pkg::rsp_type           cap_word;

   always_comb begin
      pop_out   = rsp_valid && rsp_ready;
      // a word in the read stage always finds a slot in the buffer
      room      = (3'(ob_cnt_ff) + 3'(s1_vld_ff)) < (3'd2 + 3'(pop_out));
      act_last  = (act_rem_ff == FW'(1));
      addr_full = (AW + 1)'(CIW'(act_ch_ff)) * (AW + 1)'(DEPTH) + (AW + 1)'(act_ptr_ff);
      rd_addr   = addr_full[AW-1:0];

      rd_en      = 1'b0;
      cmd_pop    = 1'b0;
      drain_done = 1'b0;
      act_in     = act_ff;
      act_ch_in  = act_ch_ff;
      act_ptr_in = act_ptr_ff;
      act_rem_in = act_rem_ff;
      s1_vld_in  = 1'b0;
      s1_ram_in  = 1'b0;
      s1_meta_in = s1_meta_ff;

      if (act_ff) begin
         if (room) begin
            rd_en                     = 1'b1;
            s1_vld_in                 = 1'b1;
            s1_ram_in                 = 1'b1;
            s1_meta_in.kind           = mbrf_pkg::KIND_SAMPLE;
            s1_meta_in.out_channel    = act_ch_ff;
            s1_meta_in.out_sample     = '0;
            s1_meta_in.accepted_count = '0;
            s1_meta_in.last           = act_last;
            act_ptr_in = (act_ptr_ff == PW'(DEPTH - 1)) ? '0 : act_ptr_ff + 1'b1;
            act_rem_in = act_rem_ff - 1'b1;
            if (act_last) begin
               act_in     = 1'b0;
               drain_done = 1'b1;
            end
         end
      end else if (cmd_valid) begin
         if (cmd_data.kind == mbrf_pkg::CMD_DRAIN) begin
            cmd_pop    = 1'b1;
            act_in     = 1'b1;
            act_ch_in  = cmd_data.channel;
            act_ptr_in = cmd_data.start[PW-1:0];
            act_rem_in = cmd_data.length[FW-1:0];
         end else if (room) begin
            cmd_pop                   = 1'b1;
            s1_vld_in                 = 1'b1;
            s1_meta_in.out_channel    = cmd_data.channel;
            s1_meta_in.out_sample     = '0;
            s1_meta_in.last           = 1'b1;
            if (cmd_data.kind == mbrf_pkg::CMD_EMPTY) begin
               s1_meta_in.kind           = mbrf_pkg::KIND_EMPTY;
               s1_meta_in.accepted_count = '0;
            end else begin
               s1_meta_in.kind           = mbrf_pkg::KIND_STATUS;
               s1_meta_in.accepted_count = cmd_data.count;
            end
         end
      end

      cap_word = s1_meta_ff;
      if (s1_ram_ff) begin
         cap_word.out_sample = rd_data;
      end

      ob_wr_in  = s1_vld_ff ? ~ob_wr_ff : ob_wr_ff;
      ob_rd_in  = pop_out ? ~ob_rd_ff : ob_rd_ff;
      ob_cnt_in = ob_cnt_ff + 2'(s1_vld_ff) - 2'(pop_out);

      rsp_valid = (ob_cnt_ff != '0);
      rsp_data  = ob_ff[ob_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff    <= 1'b0;
         s1_vld_ff <= 1'b0;
         s1_ram_ff <= 1'b0;
         ob_wr_ff  <= 1'b0;
         ob_rd_ff  <= 1'b0;
         ob_cnt_ff <= '0;
      end else begin
         act_ff    <= act_in;
         s1_vld_ff <= s1_vld_in;
         s1_ram_ff <= s1_ram_in;
         ob_wr_ff  <= ob_wr_in;
         ob_rd_ff  <= ob_rd_in;
         ob_cnt_ff <= ob_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ch_ff  <= act_ch_in;
      act_ptr_ff <= act_ptr_in;
      act_rem_ff <= act_rem_in;
      s1_meta_ff <= s1_meta_in;
      if (s1_vld_ff) begin
         ob_ff[ob_wr_ff] <= cap_word;
      end
   end

`ifndef ASSERT_OFF
   a_ob_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (3'(ob_cnt_ff) + 3'(s1_vld_ff)) <= 3'd2)
      else $error("output buffer overflow");

   a_done_while_active: assert property (@(posedge clock) disable iff (reset)
      drain_done |=> !act_ff)
      else $error("drain still active after its last read");
`endif

endmodule

// File: src/multichannel_burst_ring_fifo.sv
// ----------------------------------------------------------------------------
// multichannel_burst_ring_fifo
// Per-channel ring FIFOs of signed samples, filled by bursts, drained whole.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per push sample or one pull; rsp_* returns result
//   words (push status, pulled sample, empty-channel mark), last set on the
//   final result of each request word. Both sides use valid/ready.
//   A push sample is taken every cycle while no drain is outstanding; an
//   admitted sample is written to the sample RAM in the accept cycle. A push
//   that follows a pull of a non-empty channel waits until the drain has
//   issued its last RAM read. Status and empty results pass the command
//   queue, the read stage and the output buffer; a drain reads one sample
//   per cycle while the output buffer has room, paced by the single RAM read
//   port. Up to 4 result commands queue between the front and the back end,
//   so the front keeps taking words while results wait on rsp_ready; when
//   the queue is full, req_ready drops. A stalled receiver holds rsp_data.
//   Reset clears pointers, fill counts and burst state; sample RAM contents
//   are not cleared and are only read once committed.
// ----------------------------------------------------------------------------
module multichannel_burst_ring_fifo #(
   parameter int DEPTH    = mbrf_pkg::DEPTH_DEFAULT,
   parameter int CHANNELS = mbrf_pkg::CHANNELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mbrf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mbrf_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(CHANNELS * DEPTH);

   logic                          wr_en, rd_en;
   logic [AW-1:0]                 wr_addr, rd_addr;
   logic [mbrf_pkg::SAMPLE_W-1:0] wr_data, rd_data;
   logic                          cmd_in_valid, cmd_in_ready;
   mbrf_pkg::cmd_type             cmd_in_data;
   logic                          cmd_out_valid, cmd_pop;
   mbrf_pkg::cmd_type             cmd_out_data;
   logic                          drain_done;

   mbrf_front #(
      .DEPTH    (DEPTH),
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .cmd_valid  (cmd_in_valid),
      .cmd_ready  (cmd_in_ready),
      .cmd_data   (cmd_in_data),
      .drain_done (drain_done)
   );

   mbrf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cmd_in_valid),
      .in_ready  (cmd_in_ready),
      .in_data   (cmd_in_data),
      .out_valid (cmd_out_valid),
      .out_pop   (cmd_pop),
      .out_data  (cmd_out_data)
   );

   mbrf_back #(
      .DEPTH    (DEPTH),
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_out_valid),
      .cmd_pop    (cmd_pop),
      .cmd_data   (cmd_out_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .drain_done (drain_done)
   );

   mbrf_ram #(
      .DATA_W (mbrf_pkg::SAMPLE_W),
      .WORDS  (CHANNELS * DEPTH)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multichannel burst ring FIFO. Drives push
// bursts and drains on random channels with random idling on both sides,
// predicts every result word from its own copy of the ring state, and
// compares the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int DEPTH        = mbrf_pkg::DEPTH_DEFAULT;
   localparam int CHANNELS     = mbrf_pkg::CHANNELS_DEFAULT;
   localparam int SAMPLE_W     = mbrf_pkg::SAMPLE_W;
   localparam int CHAN_W       = mbrf_pkg::CHAN_W;
   localparam int LEN_W        = mbrf_pkg::LEN_W;
   localparam int REQ_W        = $bits(mbrf_pkg::req_type);
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 5000;
   localparam int RUN_LIMIT_NS = 5_000_000;

   typedef struct packed {
      mbrf_pkg::req_type w;
      logic              typed;
      mbrf_pkg::rsp_type want;
   } script_row_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   mbrf_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   mbrf_pkg::rsp_type rsp_data;

   // prediction state
   logic signed [SAMPLE_W-1:0] ring_mem [CHANNELS][DEPTH];
   int wr_ptr   [CHANNELS];
   int rd_ptr   [CHANNELS];
   int fill_cnt [CHANNELS];
   bit burst_ok;
   int burst_left;
   int burst_off;
   int burst_ch;
   int burst_size;

   mbrf_pkg::rsp_type step_rsp[$];
   mbrf_pkg::rsp_type due_results[$];
   script_row_type    script[$];

   int fault_count      = 0;
   int results_seen     = 0;
   int words_sent       = 0;
   int words_used       = 0;
   int bursts_admitted  = 0;
   int bursts_rejected  = 0;
   int bursts_abandoned = 0;
   int samples_drained  = 0;

   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit hold_rsp    = 1'b0;

   multichannel_burst_ring_fifo dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic mbrf_pkg::req_type req_word(mbrf_pkg::op_type op,
                                                  logic [CHAN_W-1:0] ch,
                                                  logic signed [SAMPLE_W-1:0] s,
                                                  logic [LEN_W-1:0] len, logic first);
      mbrf_pkg::req_type w;
      w.opcode         = op;
      w.channel        = ch;
      w.sample         = s;
      w.burst_len      = len;
      w.first_of_burst = first;
      return w;
   endfunction

   function automatic mbrf_pkg::rsp_type make_rsp(mbrf_pkg::kind_type k,
                                                  logic [CHAN_W-1:0] ch,
                                                  logic signed [SAMPLE_W-1:0] s,
                                                  logic [LEN_W-1:0] cnt, logic l);
      mbrf_pkg::rsp_type r;
      r.kind           = k;
      r.out_channel    = ch;
      r.out_sample     = s;
      r.accepted_count = cnt;
      r.last           = l;
      return r;
   endfunction

   // Advances the ring state by one word and leaves its results in step_rsp.
   // Returns 0 for a word the block ignores.
   function automatic bit ring_step(mbrf_pkg::req_type w);
      int c;
      int n;
      step_rsp.delete();
      c = w.channel;
      if (w.opcode == mbrf_pkg::OP_PULL) begin
         if (c >= CHANNELS) return 1'b0;
         n = fill_cnt[c];
         if (n == 0) begin
            step_rsp.push_back(make_rsp(mbrf_pkg::KIND_EMPTY, CHAN_W'(c), '0, '0, 1'b1));
            return 1'b1;
         end
         for (int i = 0; i < n; i++) begin
            step_rsp.push_back(make_rsp(mbrf_pkg::KIND_SAMPLE, CHAN_W'(c),
                                        ring_mem[c][rd_ptr[c]], '0, i == n - 1));
            rd_ptr[c] = (rd_ptr[c] + 1) % DEPTH;
         end
         fill_cnt[c] = 0;
         samples_drained += n;
         return 1'b1;
      end

      if (w.first_of_burst) begin
         if (c >= CHANNELS) return 1'b0;
         if (burst_left != 0) bursts_abandoned++;
         burst_left = 0;
         burst_off  = 0;
         burst_ok   = 1'b0;
         if (w.burst_len == 0) begin
            step_rsp.push_back(make_rsp(mbrf_pkg::KIND_STATUS, CHAN_W'(c), '0, '0, 1'b1));
            return 1'b1;
         end
         burst_ch   = c;
         burst_size = w.burst_len;
         burst_left = w.burst_len;
         burst_ok   = (DEPTH - fill_cnt[c]) > burst_size;
      end else if (burst_left == 0) begin
         return 1'b0;
      end

      // later words of a burst follow the channel and length of the first
      if (burst_ok)
         ring_mem[burst_ch][(wr_ptr[burst_ch] + burst_off) % DEPTH] = w.sample;
      burst_off++;
      burst_left--;
      if (burst_left != 0) return 1'b1;

      if (burst_ok) begin
         wr_ptr[burst_ch]   = (wr_ptr[burst_ch] + burst_size) % DEPTH;
         fill_cnt[burst_ch] += burst_size;
         bursts_admitted++;
      end else begin
         bursts_rejected++;
      end
      step_rsp.push_back(make_rsp(mbrf_pkg::KIND_STATUS, CHAN_W'(burst_ch), '0,
                                  burst_ok ? LEN_W'(burst_size) : '0, 1'b1));
      burst_ok  = 1'b0;
      burst_off = 0;
      return 1'b1;
   endfunction

   task automatic send_word(input mbrf_pkg::req_type w, input bit typed,
                            input mbrf_pkg::rsp_type want);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (ring_step(w)) words_used++;
      if (typed)
         due_results.push_back(want);
      else
         foreach (step_rsp[i]) due_results.push_back(step_rsp[i]);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         req_data  <= mbrf_pkg::req_type'(REQ_W'($urandom));
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // mix scrambles channel and length on later words and drops in pulls
   task automatic send_burst(input logic [CHAN_W-1:0] ch, input int len,
                             input int count, input bit mix);
      for (int i = 0; i < count; i++) begin
         if (mix && i != 0 && $urandom_range(0, 11) == 0)
            send_word(req_word(mbrf_pkg::OP_PULL,
                               ($urandom_range(0, 1) != 0) ? ch : CHAN_W'($urandom),
                               16'($urandom), 7'($urandom), 1'($urandom)), 1'b0, '0);
         send_word(req_word(mbrf_pkg::OP_PUSH, (i == 0 || !mix) ? ch : CHAN_W'($urandom),
                            16'($urandom),
                            (i == 0 || !mix) ? 7'(len) : 7'($urandom), i == 0),
                   1'b0, '0);
      end
   endtask

   task automatic random_traffic(input int amount);
      int upto;
      int pick;
      int len;
      logic [CHAN_W-1:0] ch;
      upto = words_used + amount;
      while (words_used < upto) begin
         pick = $urandom_range(0, 99);
         ch   = CHAN_W'($urandom_range(0, CHANNELS - 1));
         len  = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         if (pick < 50)
            send_burst(ch, len, len, 1'($urandom));
         else if (pick < 72)
            send_word(req_word(mbrf_pkg::OP_PULL, ch, 16'($urandom), 7'($urandom),
                               1'($urandom)), 1'b0, '0);
         else if (pick < 78)
            send_word(req_word(mbrf_pkg::OP_PUSH, ch, 16'($urandom), 7'd0, 1'b1), 1'b0, '0);
         else if (pick < 86)
            // continuation word; ignored unless a truncated burst is still open
            send_word(req_word(mbrf_pkg::OP_PUSH, ch, 16'($urandom), 7'($urandom), 1'b0),
                      1'b0, '0);
         else
            send_burst(ch, len, $urandom_range(1, len), 1'b1);
      end
   endtask

   initial begin : rsp_pacer
      int held;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_ready <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      mbrf_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (due_results.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("ERROR: unexpected result kind=%0d ch=%0d sample=%0d count=%0d last=%0b",
                        rsp_data.kind, rsp_data.out_channel, $signed(rsp_data.out_sample),
                        rsp_data.accepted_count, rsp_data.last);
         end else begin
            want = due_results.pop_front();
            if (rsp_data.kind !== want.kind || rsp_data.out_channel !== want.out_channel ||
                rsp_data.out_sample !== want.out_sample ||
                rsp_data.accepted_count !== want.accepted_count ||
                rsp_data.last !== want.last) begin
               fault_count++;
               if (fault_count <= 10)
                  $display({"ERROR: result %0d expected kind=%0d ch=%0d sample=%0d count=%0d ",
                            "last=%0b, got kind=%0d ch=%0d sample=%0d count=%0d last=%0b"},
                           results_seen, want.kind, want.out_channel,
                           $signed(want.out_sample), want.accepted_count, want.last,
                           rsp_data.kind, rsp_data.out_channel,
                           $signed(rsp_data.out_sample), rsp_data.accepted_count,
                           rsp_data.last);
            end
         end
      end
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("ERROR: run limit reached, %0d results outstanding", due_results.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin : main_seq
      int waited;

      script.push_back('{req_word(mbrf_pkg::OP_PULL, 2'd0, 16'sd0, 7'd0, 1'b0), 1'b1,
                         make_rsp(mbrf_pkg::KIND_EMPTY, 2'd0, '0, '0, 1'b1)});
      script.push_back('{req_word(mbrf_pkg::OP_PULL, 2'd3, 16'sd0, 7'd0, 1'b0), 1'b1,
                         make_rsp(mbrf_pkg::KIND_EMPTY, 2'd3, '0, '0, 1'b1)});
      // zero length closes at once with a zero count
      script.push_back('{req_word(mbrf_pkg::OP_PUSH, 2'd1, 16'sh1234, 7'd0, 1'b1), 1'b1,
                         make_rsp(mbrf_pkg::KIND_STATUS, 2'd1, '0, '0, 1'b1)});
      // continuation with nothing open
      script.push_back('{req_word(mbrf_pkg::OP_PUSH, 2'd2, 16'sh0f0f, 7'd5, 1'b0), 1'b0, '0});
      script.push_back('{req_word(mbrf_pkg::OP_PUSH, 2'd2, -16'sd32768, 7'd2, 1'b1), 1'b0, '0});
      // channel and length changed mid burst
      script.push_back('{req_word(mbrf_pkg::OP_PUSH, 2'd0, 16'sd32767, 7'd127, 1'b0), 1'b0, '0});
      script.push_back('{req_word(mbrf_pkg::OP_PULL, 2'd2, 16'sd0, 7'd0, 1'b0), 1'b0, '0});
      script.push_back('{req_word(mbrf_pkg::OP_PUSH, 2'd0, 16'sd0, 7'd127, 1'b1), 1'b0, '0});
      script.push_back('{req_word(mbrf_pkg::OP_PUSH, 2'd0, 16'sd1, 7'd127, 1'b0), 1'b0, '0});
      // new first word abandons the open burst
      script.push_back('{req_word(mbrf_pkg::OP_PUSH, 2'd3, -16'sd1, 7'd1, 1'b1), 1'b0, '0});
      script.push_back('{req_word(mbrf_pkg::OP_PUSH, 2'd1, 16'sd5, 7'd64, 1'b1), 1'b0, '0});
      script.push_back('{req_word(mbrf_pkg::OP_PUSH, 2'd1, 16'sh5555, 7'd3, 1'b1), 1'b0, '0});
      // pull sees nothing committed while the burst is open
      script.push_back('{req_word(mbrf_pkg::OP_PULL, 2'd1, 16'sd0, 7'd0, 1'b1), 1'b1,
                         make_rsp(mbrf_pkg::KIND_EMPTY, 2'd1, '0, '0, 1'b1)});
      script.push_back('{req_word(mbrf_pkg::OP_PUSH, 2'd3, -16'sh5556, 7'd1, 1'b0), 1'b0, '0});
      script.push_back('{req_word(mbrf_pkg::OP_PUSH, 2'd1, 16'sh7fff, 7'd3, 1'b0), 1'b0, '0});
      script.push_back('{req_word(mbrf_pkg::OP_PULL, 2'd1, 16'sd0, 7'd0, 1'b0), 1'b0, '0});
      script.push_back('{req_word(mbrf_pkg::OP_PULL, 2'd3, 16'sd0, 7'd0, 1'b0), 1'b0, '0});
      script.push_back('{req_word(mbrf_pkg::OP_PUSH, 2'd0, 16'sd0, 7'd1, 1'b1), 1'b0, '0});

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) send_word(script[i].w, script[i].typed, script[i].want);

      // free space boundaries: 63 fits an empty ring, then even 1 does not
      send_word(req_word(mbrf_pkg::OP_PULL, 2'd0, 16'sd0, 7'd0, 1'b0), 1'b0, '0);
      send_burst(2'd0, 63, 63, 1'b0);
      send_burst(2'd0, 1, 1, 1'b0);
      send_word(req_word(mbrf_pkg::OP_PULL, 2'd0, 16'sd0, 7'd0, 1'b0), 1'b0, '0);
      send_word(req_word(mbrf_pkg::OP_PULL, 2'd2, 16'sd0, 7'd0, 1'b0), 1'b0, '0);
      send_burst(2'd2, 64, 64, 1'b0);

      random_traffic(55);

      // receiver holds off while words keep coming, until req_ready drops
      hold_rsp = 1'b1;
      for (int i = 0; i < 16; i++)
         send_word(req_word((i % 2 != 0) ? mbrf_pkg::OP_PULL : mbrf_pkg::OP_PUSH,
                            CHAN_W'(i % CHANNELS), 16'($urandom), 7'd1, 1'b1), 1'b0, '0);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);

      random_traffic(45);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      random_traffic(40);

      req_valid <= 1'b0;
      waited = 0;
      while (due_results.size() != 0 && waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (due_results.size() != 0) begin
         fault_count += due_results.size();
         $display("ERROR: %0d expected results never arrived", due_results.size());
      end

      $display("Covered %0d request words (%0d effective), %0d results checked",
               words_sent, words_used, results_seen);
      $display("Bursts admitted %0d, rejected %0d, abandoned %0d; %0d samples drained",
               bursts_admitted, bursts_rejected, bursts_abandoned, samples_drained);
      if (fault_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
